@@ sv/dpws_pkg.sv @@
package dpws_pkg;

   localparam int ALIGN_BITS  = 3;
   localparam int FIELD_BITS  = 6;
   localparam int PAGE_SHIFT  = ALIGN_BITS + FIELD_BITS;
   localparam int MASK_W      = 1 << FIELD_BITS;
   localparam int HASH_W      = 13;
   localparam int CSR_W       = 11;
   localparam int FILL_W      = 11;

   localparam logic [HASH_W-1:0] HASH_MULT        = 13'd4567;
   localparam logic [CSR_W-1:0]  TABLE_SIZE_RESET = 11'd1024;

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_REM   = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NEXT  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_MISALIGN = 2'd1,
      ST_FULL     = 2'd2,
      ST_RSVD     = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic idle;
      logic accept;
      logic clr_init;
      logic clr_step;
      logic set_misalign;
      logic hash_load;
      logic hash_step;
      logic probe_init;
      logic probe_adv;
      logic rd_cur;
      logic add_write;
      logic add_full;
      logic rem_write;
      logic rep_start;
      logic rep_adv;
      logic rep_hold;
      logic ri_inc;
      logic mv_home;
      logic mv_clear;
      logic scan_init0;
      logic scan_from_probe;
      logic scan_adv;
      logic scan_hit;
      logic result_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      kind_type kind;
      logic     misaligned;
      logic     addr_zero;
      logic     clr_last;
      logic     hash_last;
      logic     probe_hit;
      logic     probe_last;
      logic     slot_empty;
      logic     rem_zero;
      logic     home_eq_cur;
      logic     rep_end;
      logic     scan_end;
      logic     scan_found;
      logic     out_busy;
   } sts_type;

endpackage

@@ sv/dpws_ram.sv @@
module dpws_ram import dpws_pkg::*; #(
   parameter int WIDTH = 103,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/dpws_ctrl.sv @@
module dpws_ctrl import dpws_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    csr_write_enable,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [15:0] {
      S_IDLE  = 16'b0000000000000001,
      S_DEC   = 16'b0000000000000010,
      S_CLR   = 16'b0000000000000100,
      S_HMUL  = 16'b0000000000001000,
      S_HDIV  = 16'b0000000000010000,
      S_PINIT = 16'b0000000000100000,
      S_PRD   = 16'b0000000001000000,
      S_PCHK  = 16'b0000000010000000,
      S_RLOOP = 16'b0000000100000000,
      S_RRD   = 16'b0000001000000000,
      S_RCHK  = 16'b0000010000000000,
      S_MV1   = 16'b0000100000000000,
      S_MV2   = 16'b0001000000000000,
      S_SRD   = 16'b0010000000000000,
      S_SCHK  = 16'b0100000000000000,
      S_DONE  = 16'b1000000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      clr_op_ff, clr_op_in;   // sweep belongs to a clear item
   logic      rep_ff, rep_in;         // probe serves the chain repair

   always_comb begin
      state_in  = state_ff;
      clr_op_in = clr_op_ff;
      rep_in    = rep_ff;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.idle = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DEC;
            end
         end
         S_DEC: begin
            rep_in = 1'b0;
            if (sts.kind == KIND_CLEAR) begin
               cmd.clr_init = 1'b1;
               clr_op_in    = 1'b1;
               state_in     = S_CLR;
            end else if (sts.kind == KIND_NEXT) begin
               if (sts.addr_zero) begin
                  cmd.scan_init0 = 1'b1;
                  state_in       = S_SRD;
               end else begin
                  state_in = S_HMUL;
               end
            end else if (sts.misaligned) begin
               cmd.set_misalign = 1'b1;
               state_in         = S_DONE;
            end else begin
               state_in = S_HMUL;
            end
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = clr_op_ff ? S_DONE : S_IDLE;
            end
         end
         S_HMUL: begin
            cmd.hash_load = 1'b1;
            state_in      = S_HDIV;
         end
         S_HDIV: begin
            cmd.hash_step = 1'b1;
            if (sts.hash_last) begin
               state_in = S_PINIT;
            end
         end
         S_PINIT: begin
            cmd.probe_init = 1'b1;
            state_in       = S_PRD;
         end
         S_PRD: begin
            state_in = S_PCHK;
         end
         S_PCHK: begin
            if (sts.probe_hit) begin
               if (rep_ff) begin
                  if (sts.home_eq_cur) begin
                     cmd.ri_inc = 1'b1;
                     state_in   = S_RLOOP;
                  end else begin
                     state_in = S_MV1;
                  end
               end else begin
                  case (sts.kind)
                     KIND_ADD: begin
                        cmd.add_write = 1'b1;
                        state_in      = S_DONE;
                     end
                     KIND_REM: begin
                        state_in = S_DONE;
                        if (!sts.slot_empty) begin
                           cmd.rem_write = 1'b1;
                           if (sts.rem_zero) begin
                              cmd.rep_start = 1'b1;
                              state_in      = S_RLOOP;
                           end
                        end
                     end
                     KIND_NEXT: begin
                        cmd.scan_from_probe = 1'b1;
                        state_in            = S_SRD;
                     end
                     default: begin
                        state_in = S_DONE;
                     end
                  endcase
               end
            end else if (sts.probe_last) begin
               if (rep_ff) begin
                  cmd.ri_inc = 1'b1;
                  state_in   = S_RLOOP;
               end else begin
                  cmd.add_full = (sts.kind == KIND_ADD);
                  state_in     = S_DONE;
               end
            end else begin
               cmd.probe_adv = 1'b1;
               state_in      = S_PRD;
            end
         end
         S_RLOOP: begin
            if (sts.rep_end) begin
               state_in = S_DONE;
            end else begin
               cmd.rep_adv = 1'b1;
               state_in    = S_RRD;
            end
         end
         S_RRD: begin
            cmd.rd_cur = 1'b1;
            state_in   = S_RCHK;
         end
         S_RCHK: begin
            if (sts.slot_empty) begin
               state_in = S_DONE;
            end else begin
               cmd.rep_hold = 1'b1;
               rep_in       = 1'b1;
               state_in     = S_HMUL;
            end
         end
         S_MV1: begin
            cmd.mv_home = 1'b1;
            state_in    = S_MV2;
         end
         S_MV2: begin
            cmd.mv_clear = 1'b1;
            cmd.ri_inc   = 1'b1;
            state_in     = S_RLOOP;
         end
         S_SRD: begin
            state_in = sts.scan_end ? S_DONE : S_SCHK;
         end
         S_SCHK: begin
            if (sts.scan_found) begin
               cmd.scan_hit = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.scan_adv = 1'b1;
               state_in     = S_SRD;
            end
         end
         S_DONE: begin
            if (!sts.out_busy) begin
               cmd.result_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // a size change empties the table
      if (csr_write_enable) begin
         cmd          = '0;
         cmd.clr_init = 1'b1;
         clr_op_in    = 1'b0;
         state_in     = S_CLR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         clr_op_ff <= 1'b0;
         rep_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_op_ff <= clr_op_in;
         rep_ff    <= rep_in;
      end
   end

endmodule

@@ sv/dpws_dp.sv @@
module dpws_dp import dpws_pkg::*; #(
   parameter int TABLE_DEPTH = 1024,
   parameter int ADDR_BITS   = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_kind,
   input  logic [ADDR_BITS-1:0] req_address,
   input  logic                 csr_write_enable,
   input  logic [CSR_W-1:0]     csr_write_data,
   input  cmd_type              cmd,
   output sts_type              sts,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ADDR_BITS-1:0] rsp_next_address,
   output logic [FILL_W-1:0]    rsp_fill_count,
   output logic [1:0]           rsp_status
);

   localparam int TAG_W  = ADDR_BITS - PAGE_SHIFT;
   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int N_W    = $clog2(TABLE_DEPTH + 1);
   localparam int PROD_W = TAG_W + HASH_W;
   localparam int HC_W   = $clog2(PROD_W);
   localparam int ENT_W  = TAG_W + MASK_W;
   localparam int AB_W   = FIELD_BITS + 1;

   logic [CSR_W-1:0]      csr_ff;
   logic [N_W-1:0]        n_eff;
   kind_type              kind_ff;
   logic [ADDR_BITS-1:0]  addr_ff;
   logic [TAG_W-1:0]      pkey_ff;
   logic [MASK_W-1:0]     hold_mask_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [N_W-1:0]        rem_ff, rem_in;
   logic [N_W:0]          rem_sh;
   logic [HC_W-1:0]       hcnt_ff;
   logic [N_W-1:0]        px_ff, px_wrap, cur_ff, cur_wrap, pc_ff, ri_ff, count_ff;
   logic [AB_W-1:0]       at_bit_ff;
   status_type            st_ff;
   logic [ADDR_BITS-1:0]  next_ff;
   logic                  rsp_valid_ff;
   logic [ADDR_BITS-1:0]  rsp_next_ff;
   logic [FILL_W-1:0]     rsp_fill_ff;
   status_type            rsp_status_ff;

   logic [TAG_W-1:0]      page;
   logic [FIELD_BITS-1:0] off;
   logic [MASK_W-1:0]     bit_sel;
   logic [ENT_W-1:0]      rdata, wdata;
   logic [TAG_W-1:0]      rd_tag;
   logic [MASK_W-1:0]     rd_mask, masked;
   logic [FIELD_BITS-1:0] ffs;
   logic                  we;
   logic [IDX_W-1:0]      waddr, raddr;

   always_comb begin
      if (csr_ff == '0) begin
         n_eff = N_W'(1);
      end else if (32'(csr_ff) > 32'(TABLE_DEPTH)) begin
         n_eff = N_W'(TABLE_DEPTH);
      end else begin
         n_eff = N_W'(csr_ff);
      end
   end

   assign page    = addr_ff[ADDR_BITS-1:PAGE_SHIFT];
   assign off     = addr_ff[PAGE_SHIFT-1:ALIGN_BITS];
   assign bit_sel = MASK_W'(1) << off;
   assign rd_tag  = rdata[ENT_W-1:MASK_W];
   assign rd_mask = rdata[MASK_W-1:0];

   assign px_wrap  = (N_W'(px_ff + 1'b1) == n_eff) ? '0 : N_W'(px_ff + 1'b1);
   assign cur_wrap = (N_W'(cur_ff + 1'b1) == n_eff) ? '0 : N_W'(cur_ff + 1'b1);

   // one remainder bit per cycle
   assign rem_sh = {rem_ff, prod_ff[PROD_W-1]};
   assign rem_in = (rem_sh >= {1'b0, n_eff}) ? N_W'(rem_sh - {1'b0, n_eff}) : N_W'(rem_sh);

   assign masked = rd_mask & ({MASK_W{1'b1}} << at_bit_ff);
   always_comb begin
      ffs = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (masked[i]) begin
            ffs = FIELD_BITS'(i);
         end
      end
   end

   always_comb begin
      we    = 1'b0;
      waddr = px_ff[IDX_W-1:0];
      wdata = '0;
      if (cmd.clr_step) begin
         we = 1'b1;
      end else if (cmd.add_write) begin
         we    = 1'b1;
         wdata = (rd_mask == '0) ? {page, bit_sel} : {rd_tag, rd_mask | bit_sel};
      end else if (cmd.rem_write) begin
         we    = 1'b1;
         wdata = {rd_tag, rd_mask & ~bit_sel};
      end else if (cmd.mv_home) begin
         we    = 1'b1;
         wdata = {pkey_ff, hold_mask_ff};
      end else if (cmd.mv_clear) begin
         we    = 1'b1;
         waddr = cur_ff[IDX_W-1:0];
         wdata = {pkey_ff, {MASK_W{1'b0}}};
      end
   end

   assign raddr = cmd.rd_cur ? cur_ff[IDX_W-1:0] : px_ff[IDX_W-1:0];

   dpws_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= TABLE_SIZE_RESET;
         px_ff        <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            csr_ff <= csr_write_data;
         end
         if (cmd.clr_init) begin
            px_ff    <= '0;
            count_ff <= '0;
         end
         if (cmd.clr_step || cmd.scan_adv) begin
            px_ff <= N_W'(px_ff + 1'b1);
         end
         if (cmd.probe_init) begin
            px_ff <= rem_ff;
         end
         if (cmd.probe_adv) begin
            px_ff <= px_wrap;
         end
         if (cmd.scan_init0) begin
            px_ff <= '0;
         end
         if (cmd.add_write && rd_mask == '0) begin
            count_ff <= N_W'(count_ff + 1'b1);
         end
         if (cmd.rep_start && count_ff != '0) begin
            count_ff <= N_W'(count_ff - 1'b1);
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.result_load) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= kind_type'(req_kind);
         addr_ff <= req_address;
         pkey_ff <= req_address[ADDR_BITS-1:PAGE_SHIFT];
         st_ff   <= ST_OK;
         next_ff <= '0;
      end
      if (cmd.set_misalign) begin
         st_ff <= ST_MISALIGN;
      end
      if (cmd.add_full) begin
         st_ff <= ST_FULL;
      end
      if (cmd.hash_load) begin
         prod_ff <= PROD_W'(pkey_ff) * PROD_W'(HASH_MULT);
         rem_ff  <= '0;
         hcnt_ff <= HC_W'(PROD_W - 1);
      end
      if (cmd.hash_step) begin
         prod_ff <= prod_ff << 1;
         rem_ff  <= rem_in;
         hcnt_ff <= HC_W'(hcnt_ff - 1'b1);
      end
      if (cmd.probe_init) begin
         pc_ff <= '0;
      end
      if (cmd.probe_adv) begin
         pc_ff <= N_W'(pc_ff + 1'b1);
      end
      if (cmd.rep_start) begin
         cur_ff <= px_ff;
         ri_ff  <= N_W'(1);
      end
      if (cmd.rep_adv) begin
         cur_ff <= cur_wrap;
      end
      if (cmd.ri_inc) begin
         ri_ff <= N_W'(ri_ff + 1'b1);
      end
      if (cmd.rep_hold) begin
         pkey_ff      <= rd_tag;
         hold_mask_ff <= rd_mask;
      end
      if (cmd.scan_init0 || cmd.scan_adv) begin
         at_bit_ff <= '0;
      end
      if (cmd.scan_from_probe) begin
         at_bit_ff <= AB_W'(off) + 1'b1;
      end
      if (cmd.scan_hit) begin
         next_ff <= {rd_tag, ffs, {ALIGN_BITS{1'b0}}};
      end
      if (cmd.result_load) begin
         rsp_next_ff   <= next_ff;
         rsp_fill_ff   <= FILL_W'(count_ff);
         rsp_status_ff <= st_ff;
      end
   end

   always_comb begin
      sts             = '0;
      sts.kind        = kind_ff;
      sts.misaligned  = |addr_ff[ALIGN_BITS-1:0];
      sts.addr_zero   = (addr_ff == '0);
      sts.clr_last    = (N_W'(px_ff + 1'b1) >= n_eff);
      sts.hash_last   = (hcnt_ff == '0);
      sts.slot_empty  = (rd_mask == '0);
      sts.probe_hit   = (rd_mask == '0) || (rd_tag == pkey_ff);
      sts.probe_last  = (N_W'(pc_ff + 1'b1) == n_eff);
      sts.rem_zero    = ((rd_mask & ~bit_sel) == '0);
      sts.home_eq_cur = (px_ff == cur_ff);
      sts.rep_end     = (ri_ff >= n_eff);
      sts.scan_end    = (px_ff >= n_eff);
      sts.scan_found  = |masked;
      sts.out_busy    = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_address = rsp_next_ff;
   assign rsp_fill_count   = rsp_fill_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

@@ sv/dirty_page_write_set_top.sv @@
// Operation: S_HMUL loads the hash product, S_HDIV yields one remainder bit per cycle,
//    S_PRD/S_PCHK check each probed slot, a next item scans slot by slot in S_SRD/S_SCHK, and a
//    remove emptying a slot repeats hash and probe for each entry of the chain after it.
// Throughput: one item at a time; the next transfer is taken after the result is queued.
// Reset: synchronous; then a clearing pass over table_size slots. The same pass runs after
//    a table_size write and for a clear item; no input transfer is taken meanwhile.
module dirty_page_write_set_top import dpws_pkg::*; #(
   parameter int TABLE_DEPTH = 1024,
   parameter int ADDR_BITS   = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_kind,
   input  logic [ADDR_BITS-1:0] req_address,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ADDR_BITS-1:0] rsp_next_address,
   output logic [FILL_W-1:0]    rsp_fill_count,
   output logic [1:0]           rsp_status,
   input  logic                 csr_write_enable,
   input  logic [CSR_W-1:0]     csr_write_data
);

   cmd_type cmd;
   sts_type sts;

   dpws_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .csr_write_enable (csr_write_enable),
      .sts              (sts),
      .cmd              (cmd)
   );

   dpws_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_BITS   (ADDR_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_next_address (rsp_next_address),
      .rsp_fill_count   (rsp_fill_count),
      .rsp_status       (rsp_status)
   );

   assign req_stall = ~cmd.idle;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_fill_count) <= 32'(TABLE_DEPTH))
      else $error("fill count above table depth");

   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> req_stall)
      else $error("transfer taken during clearing pass");

   a_err_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_next_address == '0)
      else $error("address returned with error status");

endmodule
